@@ src/haar_feature_evaluator_assert.svh @@
// Assertion macros for the Haar feature evaluator.
`ifndef HAAR_FEATURE_EVALUATOR_ASSERT_SVH
`define HAAR_FEATURE_EVALUATOR_ASSERT_SVH

`ifndef SYNTH
`define HFE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("haar feature evaluator: same-cycle check failed");
`define HFE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("haar feature evaluator: next-cycle check failed");
`else
`define HFE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define HFE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ src/hfe_pkg.sv @@
package hfe_pkg;

   localparam int MAX_SIDE    = 24;
   localparam int WINDOWS     = 4;
   localparam int VALUE_BITS  = 24;
   localparam int WIN_SIZE    = MAX_SIDE * MAX_SIDE;
   localparam int STORE_DEPTH = WINDOWS * WIN_SIZE;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

   localparam int WIN_BITS    = 2;
   localparam int COORD_BITS  = 5;
   localparam int SIDE_BITS   = 5;
   localparam int FEAT_BITS   = 28;
   localparam int SAT_MAX     = 134217727;

   localparam logic       CMD_LOAD        = 1'b0;
   localparam logic       CMD_RECT        = 1'b1;
   localparam logic [2:0] REG_WINDOW_SIDE = 3'd0;

   // One access to the integral store; read and write never share a cycle.
   typedef struct packed {
      logic                  we;
      logic                  re;
      logic [ADDR_BITS-1:0]  addr;
      logic [VALUE_BITS-1:0] wdata;
   } mem_req_type;

endpackage

@@ src/haar_feature_evaluator.sv @@
// Load item: written into the integral store at the accept edge; state stays S_IDLE.
// Rectangle item: accept, four corner reads from the single-port store in S_READ,
// S_DRAIN for the last read data, S_ADD to add into the total, S_EMIT when marked last.
// Last rectangle: result registered on leaving S_EMIT (from S_ADD, or S_IDLE if skipped).
// Skipped rectangles stay in S_IDLE unless last; a stalled result delays the next emit.
// Synchronous reset clears control, totals and window_side (24); the store is not cleared.
`include "haar_feature_evaluator_assert.svh"

module haar_feature_evaluator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_cmd,
   input  logic [hfe_pkg::WIN_BITS-1:0]         req_window,
   input  logic [hfe_pkg::COORD_BITS-1:0]       req_load_row,
   input  logic [hfe_pkg::COORD_BITS-1:0]       req_load_col,
   input  logic [hfe_pkg::VALUE_BITS-1:0]       req_load_value,
   input  logic [hfe_pkg::COORD_BITS-1:0]       req_rect_x,
   input  logic [hfe_pkg::COORD_BITS-1:0]       req_rect_y,
   input  logic [hfe_pkg::COORD_BITS-1:0]       req_rect_w,
   input  logic [hfe_pkg::COORD_BITS-1:0]       req_rect_h,
   input  logic                                 req_rect_black,
   input  logic                                 req_rect_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [hfe_pkg::FEAT_BITS-1:0] rsp_feature_value,
   output logic                                 rsp_bounds_error,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [2:0]                           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import hfe_pkg::*;

   localparam int SUM_BITS  = VALUE_BITS + 3;
   localparam int WIDE_BITS = FEAT_BITS + 2;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_DRAIN = 5'b00100,
      S_ADD   = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   function automatic logic [ADDR_BITS-1:0] addr_of(input logic [WIN_BITS-1:0] win,
                                                   input logic [COORD_BITS-1:0] row,
                                                   input logic [COORD_BITS-1:0] col);
      addr_of = ADDR_BITS'(win) * ADDR_BITS'(WIN_SIZE) + ADDR_BITS'(row) * ADDR_BITS'(MAX_SIDE)
              + ADDR_BITS'(col);
   endfunction

   function automatic logic signed [FEAT_BITS-1:0] sat(input logic signed [WIDE_BITS-1:0] v);
      if (v > WIDE_BITS'(SAT_MAX)) begin
         sat = FEAT_BITS'(SAT_MAX);
      end else if (v < -WIDE_BITS'(SAT_MAX)) begin
         sat = -FEAT_BITS'(SAT_MAX);
      end else begin
         sat = FEAT_BITS'(v);
      end
   endfunction

   state_type                    state_ff, state_in;
   logic [1:0]                   cnt_ff, cnt_in;
   logic [ADDR_BITS-1:0]         corner_addr_ff [4];
   logic [3:0]                   corner_en_ff;
   logic                         black_ff, last_ff;
   logic                         acc_vld_ff, acc_sub_ff;
   logic signed [SUM_BITS-1:0]   sum_ff;
   logic signed [FEAT_BITS-1:0]  white_total_ff, black_total_ff;
   logic                         bounds_seen_ff;
   logic [SIDE_BITS-1:0]         window_side_ff;
   logic                         rsp_valid_ff;
   logic signed [FEAT_BITS-1:0]  rsp_feature_ff;
   logic                         rsp_bounds_ff;

   logic                         accept, rect_bad, emit_go, cfg_write, side_sel;
   logic [SIDE_BITS-1:0]         side_eff;
   logic [COORD_BITS:0]          x_end, y_end;
   logic [COORD_BITS-1:0]        right, bottom, left_m1, top_m1;
   logic [ADDR_BITS-1:0]         addr_a, addr_b, addr_c, addr_d, load_addr;
   logic                         load_ok;
   mem_req_type                  mem_req;
   logic [VALUE_BITS-1:0]        rd_data;
   logic signed [SUM_BITS-1:0]   rd_ext;
   logic signed [WIDE_BITS-1:0]  total_sum;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign emit_go   = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign cfg_write = psel && penable && pwrite && pready;
   assign side_sel  = (paddr[2] == REG_WINDOW_SIDE[2]);

   assign side_eff = (window_side_ff > SIDE_BITS'(MAX_SIDE)) ? SIDE_BITS'(MAX_SIDE)
                                                            : window_side_ff;
   assign x_end    = {1'b0, req_rect_x} + {1'b0, req_rect_w};
   assign y_end    = {1'b0, req_rect_y} + {1'b0, req_rect_h};
   assign rect_bad = (req_rect_w == '0) || (req_rect_h == '0)
                  || (x_end > {1'b0, side_eff}) || (y_end > {1'b0, side_eff})
                  || (int'(req_window) >= WINDOWS);

   assign right   = COORD_BITS'(x_end - 1'b1);
   assign bottom  = COORD_BITS'(y_end - 1'b1);
   assign left_m1 = req_rect_x - 1'b1;
   assign top_m1  = req_rect_y - 1'b1;
   assign addr_a  = addr_of(req_window, bottom, right);
   assign addr_b  = addr_of(req_window, top_m1, right);
   assign addr_c  = addr_of(req_window, bottom, left_m1);
   assign addr_d  = addr_of(req_window, top_m1, left_m1);

   assign load_ok   = (int'(req_window) < WINDOWS) && (int'(req_load_row) < MAX_SIDE)
                   && (int'(req_load_col) < MAX_SIDE);
   assign load_addr = addr_of(req_window, req_load_row, req_load_col);

   always_comb begin
      mem_req.we    = accept && (req_cmd == CMD_LOAD) && load_ok;
      mem_req.re    = (state_ff == S_READ) && corner_en_ff[cnt_ff];
      mem_req.addr  = mem_req.we ? load_addr : corner_addr_ff[cnt_ff];
      mem_req.wdata = req_load_value;
   end

   hfe_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign rd_ext    = $signed({3'b000, rd_data});
   assign total_sum = black_ff ? (WIDE_BITS'(black_total_ff) + WIDE_BITS'(sum_ff))
                               : (WIDE_BITS'(white_total_ff) + WIDE_BITS'(sum_ff));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_cmd == CMD_RECT)) begin
               cnt_in = '0;
               if (rect_bad) begin
                  state_in = req_rect_last ? S_EMIT : S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 2'd3) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = S_ADD;
         S_ADD:   state_in = last_ff ? S_EMIT : S_IDLE;
         S_EMIT: begin
            if (emit_go) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cnt_ff         <= '0;
         acc_vld_ff     <= 1'b0;
         white_total_ff <= '0;
         black_total_ff <= '0;
         bounds_seen_ff <= 1'b0;
         window_side_ff <= SIDE_BITS'(MAX_SIDE);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         acc_vld_ff <= mem_req.re;
         if (cfg_write && side_sel) begin
            window_side_ff <= pwdata[SIDE_BITS-1:0];
         end
         if (accept && (req_cmd == CMD_RECT) && rect_bad) begin
            bounds_seen_ff <= 1'b1;
         end
         if (state_ff == S_ADD) begin
            if (black_ff) begin
               black_total_ff <= sat(total_sum);
            end else begin
               white_total_ff <= sat(total_sum);
            end
         end
         if (emit_go) begin
            white_total_ff <= '0;
            black_total_ff <= '0;
            bounds_seen_ff <= 1'b0;
            rsp_valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Corners a and d add, b and c subtract; the sign is registered together with the read data.
   always_ff @(posedge clock) begin
      acc_sub_ff <= cnt_ff[0] ^ cnt_ff[1];
      if (accept && (req_cmd == CMD_RECT)) begin
         corner_addr_ff[0] <= addr_a;
         corner_addr_ff[1] <= addr_b;
         corner_addr_ff[2] <= addr_c;
         corner_addr_ff[3] <= addr_d;
         corner_en_ff      <= {(req_rect_x != '0) && (req_rect_y != '0),
                               req_rect_x != '0, req_rect_y != '0, 1'b1};
         black_ff          <= req_rect_black;
         last_ff           <= req_rect_last;
         sum_ff            <= '0;
      end else if (acc_vld_ff) begin
         sum_ff <= acc_sub_ff ? (sum_ff - rd_ext) : (sum_ff + rd_ext);
      end
      if (emit_go) begin
         rsp_feature_ff <= sat(WIDE_BITS'(white_total_ff) - WIDE_BITS'(black_total_ff));
         rsp_bounds_ff  <= bounds_seen_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_feature_value = rsp_feature_ff;
   assign rsp_bounds_error  = rsp_bounds_ff;
   assign pready            = 1'b1;
   assign prdata            = side_sel ? 32'(window_side_ff) : 32'd0;

   `HFE_ASSERT_IMP(a_single_port, clock, reset, mem_req.we, !mem_req.re)
   `HFE_ASSERT_IMP(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_EMIT))
   `HFE_ASSERT_IMP(a_white_range, clock, reset, 1'b1, white_total_ff >= -SAT_MAX)
   `HFE_ASSERT_IMP(a_black_range, clock, reset, 1'b1, black_total_ff >= -SAT_MAX)
   `HFE_ASSERT_NXT(a_totals_cleared, clock, reset, emit_go, white_total_ff == 0 && black_total_ff == 0)
   `HFE_ASSERT_NXT(a_bounds_cleared, clock, reset, emit_go, !bounds_seen_ff)

endmodule

@@ src/hfe_store.sv @@
module hfe_store (
   input  logic                           clock,
   input  hfe_pkg::mem_req_type           mem_req,
   output logic [hfe_pkg::VALUE_BITS-1:0] rd_data
);
   import hfe_pkg::*;

   logic [VALUE_BITS-1:0] mem [STORE_DEPTH];
   logic [VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end else if (mem_req.re) begin
         rd_data_ff <= mem[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import hfe_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 12;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int PHASES = 6;

   typedef struct packed {
      logic                    cmd;
      logic [WIN_BITS-1:0]     window;
      logic [COORD_BITS-1:0]   load_row;
      logic [COORD_BITS-1:0]   load_col;
      logic [VALUE_BITS-1:0]   load_value;
      logic [COORD_BITS-1:0]   rect_x;
      logic [COORD_BITS-1:0]   rect_y;
      logic [COORD_BITS-1:0]   rect_w;
      logic [COORD_BITS-1:0]   rect_h;
      logic                    rect_black;
      logic                    rect_last;
   } haar_item_type;

   typedef struct packed {
      logic signed [FEAT_BITS-1:0] feature;
      logic                        bounds;
   } feature_result_type;

   typedef struct {
      haar_item_type      item;
      bit                 known;
      feature_result_type known_result;
   } directed_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_cmd = 1'b0;
   logic [WIN_BITS-1:0]           req_window = '0;
   logic [COORD_BITS-1:0]         req_load_row = '0;
   logic [COORD_BITS-1:0]         req_load_col = '0;
   logic [VALUE_BITS-1:0]         req_load_value = '0;
   logic [COORD_BITS-1:0]         req_rect_x = '0;
   logic [COORD_BITS-1:0]         req_rect_y = '0;
   logic [COORD_BITS-1:0]         req_rect_w = '0;
   logic [COORD_BITS-1:0]         req_rect_h = '0;
   logic                          req_rect_black = 1'b0;
   logic                          req_rect_last = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [FEAT_BITS-1:0]   rsp_feature_value;
   logic                          rsp_bounds_error;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [2:0]                    paddr = '0;
   logic [31:0]                   pwdata = '0;
   logic [31:0]                   prdata;
   logic                          pready;

   // Mirror of the block: integral windows, running totals and the side register.
   logic [VALUE_BITS-1:0] integral_mirror [WINDOWS][MAX_SIDE][MAX_SIDE];
   bit                    entry_loaded [WINDOWS][MAX_SIDE][MAX_SIDE];
   longint                white_total = 0;
   longint                black_total = 0;
   bit                    bounds_seen = 1'b0;
   logic [SIDE_BITS-1:0]  side_setting = 5'd24;

   feature_result_type features_due[$];
   directed_row_type   directed_rows[$];
   logic [SIDE_BITS-1:0] phase_sides [PHASES];
   int  errors = 0;
   int  items_offered = 0;
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  burst_mode = 1'b0;
   bit  hold_wanted = 1'b0;
   bit  hold_done = 1'b0;

   haar_feature_evaluator u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_window        (req_window),
      .req_load_row      (req_load_row),
      .req_load_col      (req_load_col),
      .req_load_value    (req_load_value),
      .req_rect_x        (req_rect_x),
      .req_rect_y        (req_rect_y),
      .req_rect_w        (req_rect_w),
      .req_rect_h        (req_rect_h),
      .req_rect_black    (req_rect_black),
      .req_rect_last     (req_rect_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_feature_value (rsp_feature_value),
      .rsp_bounds_error  (rsp_bounds_error),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value();
      int r;
      r = $urandom_range(0, 4);
      if (r == 0) return '1;
      if (r == 1) return '0;
      return VALUE_BITS'($urandom);
   endfunction

   function automatic haar_item_type load_item(int win, int row, int col,
                                               logic [VALUE_BITS-1:0] val);
      haar_item_type it;
      logic [31:0] noise;
      noise = $urandom;
      it.cmd = CMD_LOAD;
      it.window = win[1:0];
      it.load_row = row[4:0];
      it.load_col = col[4:0];
      it.load_value = val;
      it.rect_x = noise[4:0];
      it.rect_y = noise[9:5];
      it.rect_w = noise[14:10];
      it.rect_h = noise[19:15];
      it.rect_black = noise[20];
      it.rect_last = noise[21];
      return it;
   endfunction

   function automatic haar_item_type rect_item(int win, int x, int y, int w, int h,
                                               int black, int last);
      haar_item_type it;
      logic [31:0] noise;
      noise = $urandom;
      it.cmd = CMD_RECT;
      it.window = win[1:0];
      it.load_row = noise[4:0];
      it.load_col = noise[9:5];
      it.load_value = VALUE_BITS'($urandom);
      it.rect_x = x[4:0];
      it.rect_y = y[4:0];
      it.rect_w = w[4:0];
      it.rect_h = h[4:0];
      it.rect_black = black[0];
      it.rect_last = last[0];
      return it;
   endfunction

   function automatic directed_row_type checked_row(haar_item_type it);
      directed_row_type row;
      row.item = it;
      row.known = 1'b0;
      row.known_result = '0;
      return row;
   endfunction

   function automatic directed_row_type known_row(haar_item_type it, int feature, int bounds);
      directed_row_type row;
      row.item = it;
      row.known = 1'b1;
      row.known_result.feature = feature[FEAT_BITS-1:0];
      row.known_result.bounds = bounds[0];
      return row;
   endfunction

   // A side above MAX_SIDE acts as MAX_SIDE; a side of zero rejects every rectangle.
   function automatic int side_in_use();
      return (int'(side_setting) > MAX_SIDE) ? MAX_SIDE : int'(side_setting);
   endfunction

   function automatic bit rect_fits(haar_item_type it);
      int lim;
      lim = side_in_use();
      return it.rect_w != 0 && it.rect_h != 0
         && int'(it.rect_x) + int'(it.rect_w) <= lim
         && int'(it.rect_y) + int'(it.rect_h) <= lim
         && int'(it.window) < WINDOWS;
   endfunction

   function automatic longint clamp_feature(longint v);
      if (v > SAT_MAX) return SAT_MAX;
      if (v < -SAT_MAX) return -SAT_MAX;
      return v;
   endfunction

   // Applies one accepted item to the mirror; returns 1 when it completes a feature.
   function automatic bit evaluate_feature_item(haar_item_type it,
                                                output feature_result_type res);
      int x, y, right, bottom;
      longint corner_sum;
      res = '0;
      if (it.cmd == CMD_LOAD) begin
         if (int'(it.load_row) < MAX_SIDE && int'(it.load_col) < MAX_SIDE) begin
            integral_mirror[it.window][it.load_row][it.load_col] = it.load_value;
            entry_loaded[it.window][it.load_row][it.load_col] = 1'b1;
         end
         return 1'b0;
      end
      if (!rect_fits(it)) begin
         bounds_seen = 1'b1;
      end else begin
         x = int'(it.rect_x);
         y = int'(it.rect_y);
         right = x + int'(it.rect_w) - 1;
         bottom = y + int'(it.rect_h) - 1;
         corner_sum = longint'(integral_mirror[it.window][bottom][right]);
         if (y > 0) corner_sum -= longint'(integral_mirror[it.window][y-1][right]);
         if (x > 0) corner_sum -= longint'(integral_mirror[it.window][bottom][x-1]);
         if (x > 0 && y > 0) corner_sum += longint'(integral_mirror[it.window][y-1][x-1]);
         if (it.rect_black) black_total = clamp_feature(black_total + corner_sum);
         else white_total = clamp_feature(white_total + corner_sum);
      end
      if (!it.rect_last) return 1'b0;
      res.feature = FEAT_BITS'(clamp_feature(white_total - black_total));
      res.bounds = bounds_seen;
      white_total = 0;
      black_total = 0;
      bounds_seen = 1'b0;
      return 1'b1;
   endfunction

   task automatic offer_item(input haar_item_type it, input bit known = 1'b0,
                             input feature_result_type known_result = '0);
      int gap;
      feature_result_type res;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_cmd <= it.cmd;
      req_window <= it.window;
      req_load_row <= it.load_row;
      req_load_col <= it.load_col;
      req_load_value <= it.load_value;
      req_rect_x <= it.rect_x;
      req_rect_y <= it.rect_y;
      req_rect_w <= it.rect_w;
      req_rect_h <= it.rect_h;
      req_rect_black <= it.rect_black;
      req_rect_last <= it.rect_last;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (it.cmd == CMD_RECT || (int'(it.load_row) < MAX_SIDE && int'(it.load_col) < MAX_SIDE))
         items_offered++;
      if (evaluate_feature_item(it, res)) features_due.push_back(known ? known_result : res);
   endtask

   task automatic fill_entry(int win, int row, int col);
      if (!entry_loaded[win][row][col]) offer_item(load_item(win, row, col, pick_value()));
   endtask

   // Every corner a rectangle reads must have been loaded before it is evaluated.
   task automatic fill_corners(haar_item_type it);
      int win, x, y, right, bottom;
      win = int'(it.window);
      x = int'(it.rect_x);
      y = int'(it.rect_y);
      right = x + int'(it.rect_w) - 1;
      bottom = y + int'(it.rect_h) - 1;
      fill_entry(win, bottom, right);
      if (y > 0) fill_entry(win, y - 1, right);
      if (x > 0) fill_entry(win, bottom, x - 1);
      if (x > 0 && y > 0) fill_entry(win, y - 1, x - 1);
   endtask

   task automatic run_random_phase(int quota);
      int start, lim, n_rects, win, x, y, w, h;
      haar_item_type it;
      start = items_offered;
      lim = side_in_use();
      while (items_offered - start < quota) begin
         n_rects = $urandom_range(1, 5);
         for (int r = 0; r < n_rects; r++) begin
            if ($urandom_range(0, 4) == 0)
               offer_item(load_item($urandom_range(0, 3), $urandom_range(0, 31),
                                    $urandom_range(0, 31), pick_value()));
            if (lim == 0 || $urandom_range(0, 9) == 0) begin
               it = rect_item($urandom_range(0, 3), $urandom_range(0, 31),
                              $urandom_range(0, 31), $urandom_range(0, 31),
                              $urandom_range(0, 31), $urandom_range(0, 1),
                              int'(r == n_rects - 1));
            end else begin
               win = $urandom_range(0, 3);
               w = $urandom_range(1, lim);
               h = $urandom_range(1, lim);
               x = $urandom_range(0, lim - w);
               y = $urandom_range(0, lim - h);
               it = rect_item(win, x, y, w, h, $urandom_range(0, 1), int'(r == n_rects - 1));
            end
            if (rect_fits(it)) fill_corners(it);
            offer_item(it);
         end
      end
   endtask

   task automatic write_window_side(input logic [SIDE_BITS-1:0] side);
      logic [31:0] readback;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= REG_WINDOW_SIDE;
      pwdata <= {27'b0, side};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      side_setting = side;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      readback = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (readback !== {27'b0, side}) begin
         $display("%0t: window_side readback expected %0d actual %0d", $time, side, readback);
         errors++;
      end
   endtask

   // Quiet the sender and let every outstanding feature come back.
   task automatic drain_features();
      req_valid <= 1'b0;
      while (features_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_side
      feature_result_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (features_due.size() == 0) begin
               $display("%0t: unexpected feature: value %0d bounds %0b", $time,
                        rsp_feature_value, rsp_bounds_error);
               errors++;
            end else begin
               due = features_due.pop_front();
               if (rsp_feature_value !== due.feature) begin
                  $display("%0t: feature_value expected %0d actual %0d", $time,
                           due.feature, rsp_feature_value);
                  errors++;
               end
               if (rsp_bounds_error !== due.bounds) begin
                  $display("%0t: bounds_error expected %0b actual %0b", $time,
                           due.bounds, rsp_bounds_error);
                  errors++;
               end
            end
         end
         if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** haar_feature_evaluator: FAILED **");
         $finish;
      end
   end

   initial begin
      // Window 3 holds a corner pattern whose sum is twice the largest value, so five
      // rectangles drive a total past the saturation bound.
      directed_rows = '{
         checked_row(rect_item(0, 0, 0, 0, 1, 0, 0)),
         known_row(rect_item(1, 20, 0, 5, 1, 0, 1), 0, 1),
         known_row(rect_item(2, 3, 3, 3, 0, 1, 1), 0, 1),
         checked_row(load_item(2, 31, 0, '1)),
         checked_row(load_item(2, 0, 31, 24'h000001)),
         checked_row(load_item(3, 0, 0, '1)),
         checked_row(load_item(3, 0, 1, '0)),
         checked_row(load_item(3, 1, 0, '0)),
         checked_row(load_item(3, 1, 1, '1)),
         checked_row(rect_item(3, 1, 1, 1, 1, 0, 0)),
         checked_row(rect_item(3, 1, 1, 1, 1, 0, 0)),
         checked_row(rect_item(3, 1, 1, 1, 1, 0, 0)),
         checked_row(rect_item(3, 1, 1, 1, 1, 0, 0)),
         known_row(rect_item(3, 1, 1, 1, 1, 0, 1), SAT_MAX, 0),
         checked_row(rect_item(3, 1, 1, 1, 1, 1, 0)),
         checked_row(rect_item(3, 1, 1, 1, 1, 1, 0)),
         checked_row(rect_item(3, 1, 1, 1, 1, 1, 0)),
         checked_row(rect_item(3, 1, 1, 1, 1, 1, 0)),
         known_row(rect_item(3, 1, 1, 1, 1, 1, 1), -SAT_MAX, 0),
         checked_row(load_item(0, 23, 23, 24'hABCDEF)),
         known_row(rect_item(0, 0, 0, 24, 24, 0, 1), 24'hABCDEF, 0),
         checked_row(load_item(0, 23, 22, 24'h100000)),
         checked_row(rect_item(0, 23, 0, 1, 24, 1, 0)),
         checked_row(rect_item(0, 0, 10, 1, 20, 0, 1))
      };
      phase_sides = '{5'd1, 5'd31, 5'd0, 5'($urandom_range(2, 23)),
                      5'($urandom_range(2, 23)), 5'd24};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer_item(directed_rows[i].item, directed_rows[i].known,
                    directed_rows[i].known_result);
      drain_features();

      for (int p = 0; p < PHASES; p++) begin
         write_window_side(phase_sides[p]);
         burst_mode = (p == 1 || p == 3);
         // The receiver stops for a long stretch while the sender keeps streaming.
         if (p == 3) hold_wanted = 1'b1;
         run_random_phase(ITEMS_PER_PHASE);
         drain_features();
      end

      if (errors == 0 && features_due.size() == 0)
         $display("** haar_feature_evaluator: PASSED **");
      else
         $display("** haar_feature_evaluator: FAILED **");
      $finish;
   end

endmodule

@@ haar_feature_evaluator.f @@
+incdir+src
src/hfe_pkg.sv
src/hfe_store.sv
src/haar_feature_evaluator.sv
test/tb.sv
